// ===== rtl/lc3_instruction_executor_core_macros.svh =====
// Assertion helpers shared by the executor RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef LC3_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`define LC3_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset.
`define IEX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every clock edge, reset included.
`define IEX_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IEX_ASSERT(lbl, prop, msg)
`define IEX_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/instexe_pkg.sv =====
package instexe_pkg;

  localparam int WORD_W        = 16;
  localparam int REG_COUNT     = 8;
  localparam int RIDX_W        = $clog2(REG_COUNT);
  localparam int FLAG_W        = 3;
  localparam int MEM_WORDS_DEF = 65536;

  localparam logic [WORD_W-1:0] START_PC = 16'h3000;

  localparam logic [FLAG_W-1:0] FLAG_NONE = 3'b000;
  localparam logic [FLAG_W-1:0] FLAG_POS  = 3'b001;
  localparam logic [FLAG_W-1:0] FLAG_ZERO = 3'b010;
  localparam logic [FLAG_W-1:0] FLAG_NEG  = 3'b100;

  // Request codes
  localparam logic [1:0] REQ_EXEC  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Opcodes
  localparam logic [3:0] OP_BR  = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_LD  = 4'd2;
  localparam logic [3:0] OP_ST  = 4'd3;
  localparam logic [3:0] OP_JSR = 4'd4;
  localparam logic [3:0] OP_AND = 4'd5;
  localparam logic [3:0] OP_LDR = 4'd6;
  localparam logic [3:0] OP_STR = 4'd7;
  localparam logic [3:0] OP_NOT = 4'd9;
  localparam logic [3:0] OP_LDI = 4'd10;
  localparam logic [3:0] OP_STI = 4'd11;
  localparam logic [3:0] OP_JMP = 4'd12;
  localparam logic [3:0] OP_LEA = 4'd14;

  localparam logic [RIDX_W-1:0] LINK_REG = 3'd7;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] addr_a;
    logic [RIDX_W-1:0] addr_b;
  } regrd_t;

  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] addr;
    word_t             data;
  } regwr_t;

  typedef struct packed {
    word_t             pc_now;
    logic [FLAG_W-1:0] flags_now;
    logic              reg_was_written;
    logic [RIDX_W-1:0] reg_number;
    word_t             reg_new_value;
    logic              store_happened;
    word_t             store_address;
    word_t             store_value;
    word_t             read_word;
  } result_t;

  function automatic logic [FLAG_W-1:0] flags_for(input word_t v);
    if (v == '0) return FLAG_ZERO;
    if (v[WORD_W-1]) return FLAG_NEG;
    return FLAG_POS;
  endfunction

  function automatic word_t sext5(input word_t w);
    return {{11{w[4]}}, w[4:0]};
  endfunction

  function automatic word_t sext6(input word_t w);
    return {{10{w[5]}}, w[5:0]};
  endfunction

  function automatic word_t sext9(input word_t w);
    return {{7{w[8]}}, w[8:0]};
  endfunction

  function automatic word_t sext11(input word_t w);
    return {{5{w[10]}}, w[10:0]};
  endfunction

endpackage

// ===== rtl/instexe_ifs.sv =====
// Request channel: one beat per request.
interface instexe_req_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  instexe_pkg::word_t    instr_word;
  instexe_pkg::word_t    access_address;
  instexe_pkg::word_t    access_data;

  modport source (output valid, req_type, instr_word, access_address, access_data,
                  input ready);
  modport sink   (input valid, req_type, instr_word, access_address, access_data,
                  output ready);
endinterface

// Result channel: one beat per request.
interface instexe_rsp_if;
  logic                                   valid;
  logic                                   ready;
  instexe_pkg::word_t                     pc_now;
  logic [instexe_pkg::FLAG_W-1:0]         flags_now;
  logic                                   reg_was_written;
  logic [instexe_pkg::RIDX_W-1:0]         reg_number;
  instexe_pkg::word_t                     reg_new_value;
  logic                                   store_happened;
  instexe_pkg::word_t                     store_address;
  instexe_pkg::word_t                     store_value;
  instexe_pkg::word_t                     read_word;

  modport source (output valid, pc_now, flags_now, reg_was_written, reg_number,
                  reg_new_value, store_happened, store_address, store_value,
                  read_word, input ready);
  modport sink   (input valid, pc_now, flags_now, reg_was_written, reg_number,
                  reg_new_value, store_happened, store_address, store_value,
                  read_word, output ready);
endinterface

// ===== rtl/instexe_regfile.sv =====
// Eight-entry register file: one write port, two registered read ports.
// Unwritten entries read as zero; a read in the cycle of a write to the
// same entry returns the new value.
module instexe_regfile (
  input  logic                clk,
  input  logic                rst,
  input  instexe_pkg::regrd_t rd,
  input  instexe_pkg::regwr_t wr,
  output instexe_pkg::word_t  rd_a,
  output instexe_pkg::word_t  rd_b
);

  instexe_pkg::word_t                 regs [instexe_pkg::REG_COUNT];
  logic [instexe_pkg::REG_COUNT-1:0]  vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      regs[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (wr.en && wr.addr == rd.addr_a) begin
        rd_a <= wr.data;
      end else begin
        rd_a <= vld[rd.addr_a] ? regs[rd.addr_a] : '0;
      end
      if (wr.en && wr.addr == rd.addr_b) begin
        rd_b <= wr.data;
      end else begin
        rd_b <= vld[rd.addr_b] ? regs[rd.addr_b] : '0;
      end
    end
  end

endmodule

// ===== rtl/lc3_instruction_executor_core.sv =====
// Instruction executor: each request beat either runs one 16-bit instruction
// against the register file, PC and NZP flags, or writes or reads one word of
// the main memory, and returns exactly one result beat. The memory is a single
// port synchronous RAM of MEM_WORDS words, so memory accesses set the steps:
// ALU ops, LEA, branches, jumps, JSR/JSRR, ST, STR, memory writes and no-op
// opcodes finish in the execute step; LD, LDR, STI and memory reads in the
// memory step; LDI in the indirect step. A new request is taken in the cycle
// the previous one completes, as long as the result register is empty or
// being drained, so beats of single-step ops stream back to back. Results
// are registered and valid in the cycle after completion. Addresses are taken
// modulo MEM_WORDS; store_address reports the full 16-bit address. Memory
// reset is undefined: read only words that were written (no clearing pass).
// Registers reset to zero, PC to 0x3000, flags to none.
`include "lc3_instruction_executor_core_macros.svh"
module lc3_instruction_executor_core #(
  parameter int MEM_WORDS = instexe_pkg::MEM_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  instexe_req_if.sink    req,
  instexe_rsp_if.source  rsp
);

  localparam int          AW     = $clog2(MEM_WORDS);
  localparam int          QSTEPS = 17 - AW;
  localparam logic [31:0] MW     = 32'(MEM_WORDS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_MEM  = 4'b0100,
    S_IND  = 4'b1000
  } state_t;

  state_t                          state, state_next;
  instexe_pkg::word_t              pc, pc_next;
  logic [instexe_pkg::FLAG_W-1:0]  flags;

  // Captured request
  logic [1:0]                      req_q;
  instexe_pkg::word_t              ins_q, addr_q, data_q;

  instexe_pkg::regrd_t             rf_rd;
  instexe_pkg::regwr_t             rf_wr;
  instexe_pkg::word_t              rf_a, rf_b;

  instexe_pkg::word_t              mem [MEM_WORDS];
  instexe_pkg::word_t              mem_q;
  logic                            mem_we, mem_re;
  instexe_pkg::word_t              mem_addr, mem_wd;
  logic [AW-1:0]                   mem_idx;

  instexe_pkg::result_t            result, res_c;
  logic                            rsp_valid;

  logic                            in_ready, accept, can_out, fin_here, finish, exec_go;
  logic [3:0]                      op, in_op;
  logic [instexe_pkg::RIDX_W-1:0]  r1;
  instexe_pkg::word_t              opnd_b, pc1, pc_off9, base_off6, ea;
  logic                            in_is_store;

  // Fold a 16-bit address into the memory by restoring compare-subtract.
  function automatic logic [AW-1:0] mem_index(input instexe_pkg::word_t a);
    logic [31:0] r;
    r = 32'(a);
    for (int k = QSTEPS - 1; k >= 0; k--) begin
      if (r >= (MW << k)) r = r - (MW << k);
    end
    return r[AW-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  assign can_out  = !rsp_valid || rsp.ready;
  assign finish   = fin_here && can_out;
  assign in_ready = (state == S_IDLE) || finish;
  assign accept   = req.valid && in_ready;
  assign req.ready = in_ready;

  // Register file reads go out with the accepted beat; stores read the source
  // register on port B in place of the second ALU operand.
  assign in_op       = req.instr_word[15:12];
  assign in_is_store = (in_op == instexe_pkg::OP_ST) || (in_op == instexe_pkg::OP_STR) ||
                       (in_op == instexe_pkg::OP_STI);

  always_comb begin
    rf_rd.en     = accept;
    rf_rd.addr_a = req.instr_word[8:6];
    rf_rd.addr_b = in_is_store ? req.instr_word[11:9] : req.instr_word[2:0];
  end

  instexe_regfile u_regfile (
    .clk  (clk),
    .rst  (rst),
    .rd   (rf_rd),
    .wr   (rf_wr),
    .rd_a (rf_a),
    .rd_b (rf_b)
  );

  // ---------------------------------------------------------------------
  // Decode and address arithmetic
  // ---------------------------------------------------------------------
  assign op        = ins_q[15:12];
  assign r1        = ins_q[11:9];
  assign opnd_b    = ins_q[5] ? instexe_pkg::sext5(ins_q) : rf_b;
  assign pc1       = pc + 16'd1;
  assign pc_off9   = pc1 + instexe_pkg::sext9(ins_q);
  assign base_off6 = rf_a + instexe_pkg::sext6(ins_q);
  assign ea        = (op == instexe_pkg::OP_LDR || op == instexe_pkg::OP_STR) ?
                     base_off6 : pc_off9;

  // Stage completion: which step of the request produces the result beat.
  always_comb begin
    unique case (state)
      S_EXEC: fin_here = !(req_q == instexe_pkg::REQ_READ ||
                           (req_q == instexe_pkg::REQ_EXEC &&
                            (op == instexe_pkg::OP_LD  || op == instexe_pkg::OP_LDR ||
                             op == instexe_pkg::OP_LDI || op == instexe_pkg::OP_STI)));
      S_MEM:  fin_here = !(req_q == instexe_pkg::REQ_EXEC && op == instexe_pkg::OP_LDI);
      S_IND:  fin_here = 1'b1;
      S_IDLE: fin_here = 1'b0;
      default: fin_here = 1'b0;
    endcase
  end

  // Advance out of the execute step; hold there only when it must post a
  // result and the result register is still full.
  assign exec_go = (state == S_EXEC) && (!fin_here || can_out);

  // Next PC of an executed instruction
  always_comb begin
    pc_next = pc1;
    unique case (op)
      instexe_pkg::OP_BR: begin
        if ((r1 & flags) != '0) pc_next = pc_off9;
      end
      instexe_pkg::OP_JSR: begin
        pc_next = ins_q[11] ? (pc1 + instexe_pkg::sext11(ins_q)) : rf_a;
      end
      instexe_pkg::OP_JMP: pc_next = rf_a;
      default: pc_next = pc1;
    endcase
  end

  // ---------------------------------------------------------------------
  // Result beat for the current step
  // ---------------------------------------------------------------------
  always_comb begin
    res_c           = '0;
    res_c.pc_now    = pc;
    res_c.flags_now = flags;
    unique case (state)
      S_EXEC: begin
        unique case (req_q)
          instexe_pkg::REQ_EXEC: begin
            res_c.pc_now     = pc_next;
            res_c.reg_number = r1;
            unique case (op)
              instexe_pkg::OP_ADD: begin
                res_c.reg_was_written = 1'b1;
                res_c.reg_new_value   = rf_a + opnd_b;
              end
              instexe_pkg::OP_AND: begin
                res_c.reg_was_written = 1'b1;
                res_c.reg_new_value   = rf_a & opnd_b;
              end
              instexe_pkg::OP_NOT: begin
                res_c.reg_was_written = 1'b1;
                res_c.reg_new_value   = ~rf_a;
              end
              instexe_pkg::OP_LEA: begin
                res_c.reg_was_written = 1'b1;
                res_c.reg_new_value   = pc_off9;
              end
              instexe_pkg::OP_JSR: begin
                res_c.reg_was_written = 1'b1;
                res_c.reg_number      = instexe_pkg::LINK_REG;
                res_c.reg_new_value   = pc1;
              end
              instexe_pkg::OP_ST, instexe_pkg::OP_STR: begin
                res_c.store_happened = 1'b1;
                res_c.store_address  = ea;
                res_c.store_value    = rf_b;
              end
              default: res_c.reg_number = '0;
            endcase
            if (!res_c.reg_was_written) res_c.reg_number = '0;
          end
          instexe_pkg::REQ_WRITE: begin
            res_c.store_happened = 1'b1;
            res_c.store_address  = addr_q;
            res_c.store_value    = data_q;
          end
          default: res_c.read_word = '0;
        endcase
      end
      S_MEM: begin
        if (req_q == instexe_pkg::REQ_READ) begin
          res_c.read_word = mem_q;
        end else if (op == instexe_pkg::OP_STI) begin
          res_c.store_happened = 1'b1;
          res_c.store_address  = mem_q;
          res_c.store_value    = rf_b;
        end else begin
          res_c.reg_was_written = 1'b1;
          res_c.reg_number      = r1;
          res_c.reg_new_value   = mem_q;
        end
      end
      S_IND: begin
        res_c.reg_was_written = 1'b1;
        res_c.reg_number      = r1;
        res_c.reg_new_value   = mem_q;
      end
      S_IDLE: res_c.read_word = '0;
      default: res_c.read_word = '0;
    endcase
    // JSR links R7 without touching the flags.
    if (res_c.reg_was_written && op != instexe_pkg::OP_JSR) begin
      res_c.flags_now = instexe_pkg::flags_for(res_c.reg_new_value);
    end
  end

  always_comb begin
    rf_wr.en   = finish && res_c.reg_was_written;
    rf_wr.addr = res_c.reg_number;
    rf_wr.data = res_c.reg_new_value;
  end

  // ---------------------------------------------------------------------
  // Memory port: one access per cycle, issued only when the step advances
  // ---------------------------------------------------------------------
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = ea;
    mem_wd   = rf_b;
    if (exec_go) begin
      unique case (req_q)
        instexe_pkg::REQ_WRITE: begin
          mem_we   = 1'b1;
          mem_addr = addr_q;
          mem_wd   = data_q;
        end
        instexe_pkg::REQ_READ: begin
          mem_re   = 1'b1;
          mem_addr = addr_q;
        end
        instexe_pkg::REQ_EXEC: begin
          unique case (op)
            instexe_pkg::OP_ST, instexe_pkg::OP_STR: mem_we = 1'b1;
            instexe_pkg::OP_LD, instexe_pkg::OP_LDR,
            instexe_pkg::OP_LDI, instexe_pkg::OP_STI: mem_re = 1'b1;
            default: mem_we = 1'b0;
          endcase
        end
        default: mem_we = 1'b0;
      endcase
    end else if (state == S_MEM && req_q == instexe_pkg::REQ_EXEC) begin
      // Second access of an indirect op goes through the pointer just read.
      mem_addr = mem_q;
      if (op == instexe_pkg::OP_LDI) mem_re = 1'b1;
      if (op == instexe_pkg::OP_STI) mem_we = can_out;
    end
  end

  assign mem_idx = mem_index(mem_addr);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_idx] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_idx];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    priority if (accept) begin
      state_next = S_EXEC;
    end else if (finish) begin
      state_next = S_IDLE;
    end else if (exec_go) begin
      state_next = S_MEM;
    end else if (state == S_MEM && !fin_here) begin
      state_next = S_IND;
    end else begin
      state_next = state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req.req_type;
      ins_q  <= req.instr_word;
      addr_q <= req.access_address;
      data_q <= req.access_data;
    end
  end

  // Commit the PC as the execute step leaves; later steps never change it.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= instexe_pkg::START_PC;
    end else if (exec_go && req_q == instexe_pkg::REQ_EXEC) begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= instexe_pkg::FLAG_NONE;
    end else if (finish && res_c.reg_was_written && op != instexe_pkg::OP_JSR) begin
      flags <= res_c.flags_now;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result <= res_c;
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.pc_now          = result.pc_now;
  assign rsp.flags_now       = result.flags_now;
  assign rsp.reg_was_written = result.reg_was_written;
  assign rsp.reg_number      = result.reg_number;
  assign rsp.reg_new_value   = result.reg_new_value;
  assign rsp.store_happened  = result.store_happened;
  assign rsp.store_address   = result.store_address;
  assign rsp.store_value     = result.store_value;
  assign rsp.read_word       = result.read_word;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `IEX_ASSERT(a_mem_single_port, !(mem_we && mem_re), "memory read and write in one cycle")
  // Hold in the indirect step while the result register is full.
  `IEX_ASSERT(a_ind_after_mem, (state == S_IND) |-> ($past(state) == S_MEM || $past(state) == S_IND), "indirect step out of order")
  `IEX_ASSERT(a_pc_from_exec, (!$past(rst) && (pc != $past(pc))) |-> $past(state == S_EXEC && req_q == instexe_pkg::REQ_EXEC), "PC moved outside execute step")
  `IEX_ASSERT_RST(a_rsp_clear_after_rst, $past(rst) |-> !rsp_valid, "result valid after reset")

endmodule
